// ===== sv/stereo_linear_resampler_macros.svh =====
// ----------------------------------------------------------------------------
// Stereo linear resampler assertion macros
// Shorthand for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef STEREO_LINEAR_RESAMPLER_MACROS_SVH
`define STEREO_LINEAR_RESAMPLER_MACROS_SVH

// same-cycle implication
`define SLR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SLR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/slr_pkg.sv =====
// ----------------------------------------------------------------------------
// slr_pkg
// Shared types and fixed constants of the stereo linear resampler.
// ----------------------------------------------------------------------------
package slr_pkg;

  localparam int unsigned STEP_W      = 20;
  localparam int unsigned LEN_W       = 21;
  localparam int unsigned MAX_RESULTS = 64;

  localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;
  localparam logic [LEN_W-1:0]  LEN_RESET  = 21'd1024;

  typedef enum logic [0:0] {
    REG_STEP_RATIO    = 1'b0,
    REG_OUTPUT_LENGTH = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [STEP_W-1:0] step_ratio;
    logic [LEN_W-1:0]  output_length;
  } cfg_t;

endpackage

// ===== sv/slr_regs.sv =====
// ----------------------------------------------------------------------------
// slr_regs
// APB register file: step ratio and output length.
// ----------------------------------------------------------------------------
module slr_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output slr_pkg::cfg_t      cfg_o
);

  logic [slr_pkg::STEP_W-1:0] step_q;
  logic [slr_pkg::LEN_W-1:0]  len_q;
  logic                       wr_en;
  slr_pkg::reg_idx_e          idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = slr_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= slr_pkg::STEP_RESET;
      len_q  <= slr_pkg::LEN_RESET;
    end else if (wr_en) begin
      case (idx)
        slr_pkg::REG_STEP_RATIO:    step_q <= pwdata[slr_pkg::STEP_W-1:0];
        slr_pkg::REG_OUTPUT_LENGTH: len_q  <= pwdata[slr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      slr_pkg::REG_STEP_RATIO:    prdata = {{(32-slr_pkg::STEP_W){1'b0}}, step_q};
      slr_pkg::REG_OUTPUT_LENGTH: prdata = {{(32-slr_pkg::LEN_W){1'b0}}, len_q};
      default:                    prdata = '0;
    endcase
  end

  assign cfg_o.step_ratio    = step_q;
  assign cfg_o.output_length = len_q;

endmodule

// ===== sv/slr_front.sv =====
// ----------------------------------------------------------------------------
// slr_front
// Input side: takes source frames and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module slr_front #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] left_in_i,
  input  logic [SAMPLE_BITS-1:0] right_in_i,
  input  logic                   last_frame_i,
  output logic                   q_valid_o,
  input  logic                   q_pop_i,
  output logic [SAMPLE_BITS-1:0] q_left_o,
  output logic [SAMPLE_BITS-1:0] q_right_o,
  output logic                   q_last_o
);

  logic [SAMPLE_BITS-1:0] mem_l    [2];
  logic [SAMPLE_BITS-1:0] mem_r    [2];
  logic                   mem_last [2];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             count_q, count_d;
  logic                   push;

  assign in_stall_o = count_q[1];
  assign push       = in_valid_i & ~count_q[1];
  assign q_valid_o  = count_q != 2'd0;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ q_pop_i;
    count_d  = count_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_l[wr_ptr_q]    <= left_in_i;
      mem_r[wr_ptr_q]    <= right_in_i;
      mem_last[wr_ptr_q] <= last_frame_i;
    end
  end

  assign q_left_o  = mem_l[rd_ptr_q];
  assign q_right_o = mem_r[rd_ptr_q];
  assign q_last_o  = mem_last[rd_ptr_q];

endmodule

// ===== sv/slr_back.sv =====
// ----------------------------------------------------------------------------
// slr_back
// Interpolation engine: steps the output position across the queued frame,
// one output frame per cycle unless stalled; multiply stage, output register.
// ----------------------------------------------------------------------------
module slr_back #(
  parameter int unsigned INDEX_BITS  = 20,
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  slr_pkg::cfg_t          cfg_i,
  input  logic                   q_valid_i,
  output logic                   q_pop_o,
  input  logic [SAMPLE_BITS-1:0] q_left_i,
  input  logic [SAMPLE_BITS-1:0] q_right_i,
  input  logic                   q_last_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SAMPLE_BITS-1:0] left_out_o,
  output logic [SAMPLE_BITS-1:0] right_out_o,
  output logic                   last_of_item_o,
  output logic                   run_done_o
);

  localparam int unsigned FRAME_W = INDEX_BITS + 1;
  localparam int unsigned POS_W   = INDEX_BITS + 1 + FRAC_BITS;
  localparam int unsigned SUM_W   =
    ((POS_W > slr_pkg::STEP_W) ? POS_W : slr_pkg::STEP_W) + 1;
  localparam int unsigned CNT_W   = $clog2(slr_pkg::MAX_RESULTS + 1);
  localparam int unsigned PROD_W  = SAMPLE_BITS + FRAC_BITS + 2;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(slr_pkg::MAX_RESULTS);

  // run state
  logic [SAMPLE_BITS-1:0]       prev_l_q, prev_r_q;
  logic [FRAME_W-1:0]           frames_q;
  logic [POS_W-1:0]             pos_q;
  logic [slr_pkg::LEN_W-1:0]    given_q;
  logic [CNT_W-1:0]             cnt_q;

  // decision logic
  logic [FRAME_W-1:0]           pos_int, pos_nxt_int;
  logic                         have_prev, room, owe, room_n, owe_n;
  logic                         can_interp, can_repeat, emit, more;
  logic [FRAC_BITS-1:0]         frac;
  logic [SUM_W-1:0]             pos_sum;
  logic [POS_W-1:0]             pos_nxt;
  logic [slr_pkg::LEN_W-1:0]    given_nxt;
  logic [CNT_W-1:0]             cnt_nxt;
  logic                         step, done_item, is_last, is_done;

  // multiply path
  logic signed [SAMPLE_BITS:0]   diff_l, diff_r;
  logic signed [FRAC_BITS:0]     frac_s;
  logic signed [PROD_W-1:0]      prod_l, prod_r;
  logic [SAMPLE_BITS-1:0]        base_l, base_r;

  // multiply stage
  logic                          a_valid_q;
  logic signed [PROD_W-1:0]      a_prod_l_q, a_prod_r_q;
  logic [SAMPLE_BITS-1:0]        a_base_l_q, a_base_r_q;
  logic                          a_last_q, a_done_q;
  logic                          a_ready, advance;
  logic signed [PROD_W-1:0]      sh_l, sh_r;

  // output register
  logic                          out_valid_q;
  logic [SAMPLE_BITS-1:0]        out_l_q, out_r_q;
  logic                          out_last_q, out_done_q;

  assign advance = ~out_valid_q | ~out_stall_i;
  assign a_ready = ~a_valid_q | advance;

  always_comb begin
    pos_int    = pos_q[POS_W-1:FRAC_BITS];
    have_prev  = frames_q != '0;
    room       = cnt_q < CNT_MAX;
    owe        = given_q < cfg_i.output_length;
    can_interp = have_prev & room & owe & (pos_int < frames_q);
    can_repeat = q_last_i & room & owe;
    emit       = can_interp | can_repeat;
    // positions left behind by the per-item cap read as the previous frame
    frac       = (can_interp && (pos_int == frames_q - FRAME_W'(1)))
                 ? pos_q[FRAC_BITS-1:0] : '0;

    pos_sum     = SUM_W'(pos_q) + SUM_W'(cfg_i.step_ratio);
    pos_nxt     = (|pos_sum[SUM_W-1:POS_W]) ? {POS_W{1'b1}} : pos_sum[POS_W-1:0];
    pos_nxt_int = pos_nxt[POS_W-1:FRAC_BITS];
    given_nxt   = given_q + slr_pkg::LEN_W'(1);
    cnt_nxt     = cnt_q + CNT_W'(1);
    room_n      = cnt_nxt < CNT_MAX;
    owe_n       = given_nxt < cfg_i.output_length;
    more        = room_n & owe_n & ((have_prev & (pos_nxt_int < frames_q)) | q_last_i);
    is_last     = ~more;
    is_done     = ~owe_n | (q_last_i & ~more);

    step      = q_valid_i & a_ready;
    done_item = step & (~emit | ~more);
  end

  assign q_pop_o = done_item;

  always_comb begin
    diff_l = $signed({q_left_i[SAMPLE_BITS-1], q_left_i})
           - $signed({prev_l_q[SAMPLE_BITS-1], prev_l_q});
    diff_r = $signed({q_right_i[SAMPLE_BITS-1], q_right_i})
           - $signed({prev_r_q[SAMPLE_BITS-1], prev_r_q});
    frac_s = $signed({1'b0, frac});
    prod_l = diff_l * frac_s;
    prod_r = diff_r * frac_s;
    base_l = can_interp ? prev_l_q : q_left_i;
    base_r = can_interp ? prev_r_q : q_right_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_l_q <= '0;
      prev_r_q <= '0;
      frames_q <= '0;
      pos_q    <= '0;
      given_q  <= '0;
      cnt_q    <= '0;
    end else begin
      if (step && emit) begin
        pos_q   <= pos_nxt;
        given_q <= given_nxt;
        cnt_q   <= cnt_nxt;
      end
      if (done_item) begin
        cnt_q <= '0;
        if (q_last_i) begin
          prev_l_q <= '0;
          prev_r_q <= '0;
          frames_q <= '0;
          pos_q    <= '0;
          given_q  <= '0;
        end else begin
          prev_l_q <= q_left_i;
          prev_r_q <= q_right_i;
          if (frames_q != {FRAME_W{1'b1}}) begin
            frames_q <= frames_q + FRAME_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= step & emit;
      end
      if (advance) begin
        out_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && step && emit) begin
      a_prod_l_q <= prod_l;
      a_prod_r_q <= prod_r;
      a_base_l_q <= base_l;
      a_base_r_q <= base_r;
      a_last_q   <= is_last;
      a_done_q   <= is_done;
    end
  end

  // arithmetic shift floors toward minus infinity
  assign sh_l = a_prod_l_q >>> FRAC_BITS;
  assign sh_r = a_prod_r_q >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (advance && a_valid_q) begin
      out_l_q    <= a_base_l_q + sh_l[SAMPLE_BITS-1:0];
      out_r_q    <= a_base_r_q + sh_r[SAMPLE_BITS-1:0];
      out_last_q <= a_last_q;
      out_done_q <= a_done_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_out_o     = out_l_q;
  assign right_out_o    = out_r_q;
  assign last_of_item_o = out_last_q;
  assign run_done_o     = out_done_q;

endmodule

// ===== sv/stereo_linear_resampler.sv =====
// ----------------------------------------------------------------------------
// stereo_linear_resampler
// Stereo sample-rate converter by linear interpolation between source frames.
// ----------------------------------------------------------------------------
// Source frames come in on the input channel (in_valid_i / in_stall_o), one
// beat per frame; last_frame_i marks the final frame of a run. Each frame
// gives zero to 64 output beats on the output channel (out_valid_o /
// out_stall_i); last_of_item_o marks the final beat of a frame and
// run_done_o the final beat of a run. step_ratio and output_length are set
// over the APB port; the user must write them only while the block is idle,
// which the block itself does not enforce. An input beat passes through the
// queue, the multiply stage and the output register before the first output
// beat of its frame is valid. The engine gives one output beat per clock
// while the output is not stalled; a frame holds it until all its output
// beats are given, and a two-entry queue lets input beats arrive while the
// engine is busy. Reset clears the run state and loads step_ratio = 1.0 and
// output_length = 1024. A stall on the output holds the output register; the
// engine and then the queue fill up and in_stall_o rises.
// ----------------------------------------------------------------------------
module stereo_linear_resampler #(
  parameter int unsigned INDEX_BITS  = 20,
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] left_in_i,
  input  logic [SAMPLE_BITS-1:0] right_in_i,
  input  logic                   last_frame_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SAMPLE_BITS-1:0] left_out_o,
  output logic [SAMPLE_BITS-1:0] right_out_o,
  output logic                   last_of_item_o,
  output logic                   run_done_o
);

  slr_pkg::cfg_t          cfg;
  logic                   q_valid, q_pop, q_last;
  logic [SAMPLE_BITS-1:0] q_left, q_right;

  slr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  slr_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .left_in_i    (left_in_i),
    .right_in_i   (right_in_i),
    .last_frame_i (last_frame_i),
    .q_valid_o    (q_valid),
    .q_pop_i      (q_pop),
    .q_left_o     (q_left),
    .q_right_o    (q_right),
    .q_last_o     (q_last)
  );

  slr_back #(
    .INDEX_BITS  (INDEX_BITS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_left_i       (q_left),
    .q_right_i      (q_right),
    .q_last_i       (q_last),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o),
    .last_of_item_o (last_of_item_o),
    .run_done_o     (run_done_o)
  );

endmodule

// ===== sv/slr_checker.sv =====
// ----------------------------------------------------------------------------
// slr_checker
// Port-level checks on the resampler, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "stereo_linear_resampler_macros.svh"

module slr_checker #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic [2:0]             paddr,
  input logic [31:0]            pwdata,
  input logic [31:0]            prdata,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [SAMPLE_BITS-1:0] left_out_o,
  input logic [SAMPLE_BITS-1:0] right_out_o,
  input logic                   last_of_item_o,
  input logic                   run_done_o
);

  // a stalled output beat stays put
  `SLR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(left_out_o) && $stable(right_out_o) && $stable(last_of_item_o) && $stable(run_done_o), "stalled output beat changed")

  // the end of a run is always the end of its frame
  `SLR_ASSERT_IMP(a_done_last, clk_i, rst_ni, out_valid_o && run_done_o, last_of_item_o, "run_done without last_of_item")

  // step ratio reads back what was just written
  `SLR_ASSERT_IMP(a_step_readback, clk_i, rst_ni, $past(psel && penable && pwrite && !paddr[2]) && psel && !pwrite && !paddr[2], prdata[19:0] == $past(pwdata[19:0]), "step ratio readback mismatch")

endmodule

bind stereo_linear_resampler slr_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_slr_checker (.*);

// ===== dv/stereo_linear_resampler_tb.sv =====
// ----------------------------------------------------------------------------
// stereo_linear_resampler_tb
// Self-checking bench for the stereo linear resampler. Source frames go in
// through the valid/stall channel, registers are set over APB between runs,
// and every output beat is checked against a cycle-free model of the
// interpolator kept in a scoreboard class.
// ----------------------------------------------------------------------------
module stereo_linear_resampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     SW        = 24;
  localparam int     FRAC      = 16;
  localparam longint POS_MAX   = (64'd1 << 37) - 1;
  localparam int     MAX_CYCLE = 300000;

  typedef struct {
    logic [SW-1:0] left;
    logic [SW-1:0] right;
    bit            item_end;
    bit            run_end;
  } out_frame_t;

  class resampler_scoreboard;
    logic [slr_pkg::STEP_W-1:0] step_ratio;
    logic [slr_pkg::LEN_W-1:0]  out_len;
    logic [SW-1:0]              prev_left;
    logic [SW-1:0]              prev_right;
    logic [20:0]                frames_seen;
    logic [36:0]                out_pos;
    logic [slr_pkg::LEN_W-1:0]  given;
    out_frame_t                 owed_frames[$];
    out_frame_t                 burst[$];
    int                         errors;

    function new();
      step_ratio = slr_pkg::STEP_RESET;
      out_len    = slr_pkg::LEN_RESET;
      errors     = 0;
      clear_run();
    endfunction

    function void clear_run();
      prev_left   = '0;
      prev_right  = '0;
      frames_seen = '0;
      out_pos     = '0;
      given       = '0;
    endfunction

    function void set_reg(slr_pkg::reg_idx_e idx, logic [31:0] value);
      case (idx)
        slr_pkg::REG_STEP_RATIO:    step_ratio = value[slr_pkg::STEP_W-1:0];
        slr_pkg::REG_OUTPUT_LENGTH: out_len    = value[slr_pkg::LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    // a + floor((b - a) * frac / 2^FRAC)
    function longint interp(longint a, longint b, longint frac);
      longint prod;
      prod = (b - a) * frac;
      return a + (prod >>> FRAC);
    endfunction

    function void add_out(longint l, longint r);
      out_frame_t f;
      longint     np;
      f.left     = l[SW-1:0];
      f.right    = r[SW-1:0];
      f.item_end = 1'b0;
      given++;
      f.run_end  = (given >= out_len);
      np = longint'(out_pos) + longint'(step_ratio);
      out_pos = (np > POS_MAX) ? '1 : np[36:0];
      burst.push_back(f);
    endfunction

    function void take_frame(logic [SW-1:0] l_raw, logic [SW-1:0] r_raw, bit is_last);
      longint     cl, cr, pl, pr, lo, hi, frac;
      out_frame_t tail;
      cl = longint'($signed(l_raw));
      cr = longint'($signed(r_raw));
      pl = longint'($signed(prev_left));
      pr = longint'($signed(prev_right));
      burst.delete();
      if (frames_seen != '0) begin
        lo = (longint'(frames_seen) - 1) << FRAC;
        hi = longint'(frames_seen) << FRAC;
        while (burst.size() < slr_pkg::MAX_RESULTS && given < out_len &&
               longint'(out_pos) < hi) begin
          // a position left behind by the per-frame cap reads as the old frame
          frac = (longint'(out_pos) >= lo) ? longint'(out_pos) - lo : 0;
          add_out(interp(pl, cl, frac), interp(pr, cr, frac));
        end
      end
      if (is_last) begin
        while (burst.size() < slr_pkg::MAX_RESULTS && given < out_len) add_out(cl, cr);
        if (burst.size() > 0) begin
          tail = burst.pop_back();
          tail.run_end = 1'b1;
          burst.push_back(tail);
        end
        clear_run();
      end else begin
        prev_left  = l_raw;
        prev_right = r_raw;
        if (frames_seen != '1) frames_seen++;
      end
      if (burst.size() > 0) begin
        tail = burst.pop_back();
        tail.item_end = 1'b1;
        burst.push_back(tail);
      end
      foreach (burst[i]) owed_frames.push_back(burst[i]);
    endfunction

    function void check_frame(logic [SW-1:0] l, logic [SW-1:0] r, bit ie, bit re);
      out_frame_t f;
      if (owed_frames.size() == 0) begin
        flag($sformatf("unexpected output beat L=%h R=%h item_end=%b run_end=%b",
                       l, r, ie, re));
        return;
      end
      f = owed_frames.pop_front();
      if (f.left !== l || f.right !== r || f.item_end !== ie || f.run_end !== re)
        flag($sformatf({"output mismatch: exp L=%h R=%h item_end=%b run_end=%b",
                        " / got L=%h R=%h item_end=%b run_end=%b"},
                       f.left, f.right, f.item_end, f.run_end, l, r, ie, re));
    endfunction
  endclass

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          psel      = 1'b0;
  logic          penable   = 1'b0;
  logic          pwrite    = 1'b0;
  logic [2:0]    paddr     = '0;
  logic [31:0]   pwdata    = '0;
  logic [31:0]   prdata;
  logic          pready;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  logic [SW-1:0] left_in   = '0;
  logic [SW-1:0] right_in  = '0;
  logic          last_in   = 1'b0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [SW-1:0] left_out;
  logic [SW-1:0] right_out;
  logic          item_end;
  logic          run_end;

  bit          calm      = 1'b0;
  bit          hold_req  = 1'b0;
  int          hold_left = 0;
  int unsigned cycles    = 0;

  resampler_scoreboard sb;

  stereo_linear_resampler dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .left_in_i      (left_in),
    .right_in_i     (right_in),
    .last_frame_i   (last_in),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .left_out_o     (left_out),
    .right_out_o    (right_out),
    .last_of_item_o (item_end),
    .run_done_o     (run_end)
  );

  always #4 clk = ~clk;

  // output side: random stalls, or one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 35);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_frame(left_out, right_out, item_end, run_end);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLE) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic bit gap_roll();
    return !calm && ($urandom_range(0, 99) < 35);
  endfunction

  task automatic send_frame(logic [SW-1:0] l, logic [SW-1:0] r, bit is_last);
    while (gap_roll()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    left_in  <= l;
    right_in <= r;
    last_in  <= is_last;
    do @(posedge clk); while (in_stall);
    sb.take_frame(l, r, is_last);
    @(negedge clk);
  endtask

  // drain all owed beats, then give frames that make no output time to retire
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.owed_frames.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(slr_pkg::reg_idx_e idx, logic [31:0] value);
    logic [31:0] rd;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if (idx == slr_pkg::REG_STEP_RATIO
        ? rd[slr_pkg::STEP_W-1:0] !== value[slr_pkg::STEP_W-1:0]
        : rd[slr_pkg::LEN_W-1:0] !== value[slr_pkg::LEN_W-1:0])
      sb.flag($sformatf("register readback %s: wrote %h read %h", idx.name(), value, rd));
  endtask

  task automatic configure(logic [31:0] step, logic [31:0] len);
    settle();
    write_reg(slr_pkg::REG_STEP_RATIO, step);
    write_reg(slr_pkg::REG_OUTPUT_LENGTH, len);
  endtask

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(0, 4))
      0:       return 24'h7fffff;
      1:       return 24'h800000;
      2:       return $urandom_range(0, 1) ? 24'h000000 : 24'hffffff;
      default: return SW'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 3))
      0:       return 32'd4096;
      1:       return 32'd1048575;
      default: return $urandom_range(4096, 196608);
    endcase
  endfunction

  function automatic logic [31:0] pick_len();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(1, 12);
      1:       return 32'd1048576;
      2:       return $urandom_range(13, 200);
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  // mostly clean runs; now and then a stray or missing end-of-run flag
  task automatic random_run(int n);
    bit is_last;
    for (int i = 0; i < n; i++) begin
      is_last = (i == n - 1);
      if ($urandom_range(0, 9) == 0) is_last = $urandom_range(0, 1);
      send_frame(pick_sample(), pick_sample(), is_last);
    end
  endtask

  initial begin
    int items_left;
    int n;
    sb = new();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: unit step, full-scale swings, owed tail cut at the cap
    send_frame(24'h7fffff, 24'h800000, 1'b0);
    send_frame(24'h800000, 24'h7fffff, 1'b0);
    send_frame(24'h000000, 24'hffffff, 1'b0);
    send_frame(24'hffffff, 24'h000001, 1'b1);
    // run of a single frame
    send_frame(24'h00007b, 24'hfffe38, 1'b1);

    // fractional positions; run completes, then idles until its last frame
    configure(32'd24576, 32'd5);
    send_frame(24'h7fffff, 24'h800000, 1'b0);
    send_frame(24'h800000, 24'h7fffff, 1'b0);
    send_frame(24'h123456, 24'hfedcba, 1'b0);
    send_frame(24'h654321, 24'h0abcde, 1'b1);
    send_frame(24'h3c3c3c, 24'hc3c3c3, 1'b0);
    send_frame(24'h0f0f0f, 24'hf0f0f0, 1'b1);

    configure(32'd65536, 32'd0);
    send_frame(24'h7fffff, 24'h7fffff, 1'b0);
    send_frame(24'h800000, 24'h800000, 1'b1);

    configure(32'd1048575, 32'd1048576);
    send_frame(24'h7fffff, 24'h7fffff, 1'b0);
    send_frame(24'h800000, 24'h800000, 1'b0);
    send_frame(24'h000000, 24'h000000, 1'b1);

    configure(32'd4096, 32'd1048576);
    send_frame(24'h800000, 24'h7fffff, 1'b0);
    send_frame(24'h7fffff, 24'h800000, 1'b0);
    send_frame(24'h555555, 24'haaaaaa, 1'b1);

    // step small enough that the cap leaves positions behind the frame pair
    configure(32'd800, 32'd1048576);
    send_frame(24'h7fffff, 24'h800000, 1'b0);
    send_frame(24'h800000, 24'h7fffff, 1'b0);
    send_frame(24'h400000, 24'hc00000, 1'b0);
    send_frame(24'h000001, 24'hfffffe, 1'b1);

    for (int p = 0; p < 6; p++) begin
      if (p == 3) configure(32'd32768, 32'd1048576);
      else configure(pick_step(), pick_len());
      calm = (p == 2);
      if (p == 3) hold_req = 1'b1;
      items_left = 13;
      while (items_left > 0) begin
        n = $urandom_range(1, 8);
        if (n > items_left) n = items_left;
        random_run(n);
        items_left -= n;
      end
    end
    calm = 1'b0;

    settle();
    if (sb.errors == 0 && sb.owed_frames.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
